// File: hdl/intel_hex_record_parser_core_macros.svh
// Assertion macros for the Intel HEX record parser.
`ifndef INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH
`define INTEL_HEX_RECORD_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IHEX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihex: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihex: next-cycle check failed");

`endif

// File: hdl/ihex_pkg.sv
package ihex_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] HEX_TEN    = 8'd10;

    localparam logic [1:0] ADDR_LAST_NIBBLE = 2'd3;

    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_WINDOW_START = 1'b0;
    localparam cfg_index_t CFG_WINDOW_END   = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_COUNT = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_DATA  = 3'd4,
        PH_CHECK = 3'd5
    } phase_t;

    // Non-hex characters decode as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] diff;
        diff = 8'd0;
        if (ch >= CHAR_0 && ch <= CHAR_9)
        begin
            diff = ch - CHAR_0;
        end
        else if (ch >= CHAR_UA && ch <= CHAR_UF)
        begin
            diff = ch - CHAR_UA + HEX_TEN;
        end
        else if (ch >= CHAR_LA && ch <= CHAR_LF)
        begin
            diff = ch - CHAR_LA + HEX_TEN;
        end
        return diff[3:0];
    endfunction

endpackage

// File: hdl/intel_hex_record_parser_core.sv
// Intel HEX record parser core.
// Input channel: one ASCII character per transfer on char_in (in_valid/in_ready).
// The parser waits for ':', then reads byte count, 16-bit address, record type,
// data bytes and checksum as hex digit pairs (upper or lower case; any other
// character reads as digit 0). The checksum is skipped, not checked.
// Output channel: one transfer per kept data byte of a type-0 record, carrying
// data_byte and image_offset = address - window_start (mod 65536). A byte is
// kept when its address lies in [window_start, window_end).
// Config channel: cfg_index 0 writes window_start, 1 writes window_end; always
// ready, write only while the parser is idle.
// Latency: a result is valid the cycle after the character that completes the
// data byte. Throughput: one character per cycle while in_ready is high; the parse
// state and the output register update in the same cycle as the input transfer.
// Stall: results sit in one output register; in_ready drops only while that
// register is full and out_ready is low, so no result is lost.
// Reset: parser idle, window [0, 65535), output register empty.
`include "intel_hex_record_parser_core_macros.svh"

module intel_hex_record_parser_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            char_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           image_offset,
    output logic [7:0]            data_byte,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  ihex_pkg::cfg_index_t  cfg_index,
    input  logic [15:0]           cfg_data
);
    import ihex_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  nib_idx_reg, nib_idx_next;
    logic [11:0] high_reg, high_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] rec_addr_reg, rec_addr_next;
    logic [7:0]  rec_type_reg, rec_type_next;
    logic [7:0]  data_idx_reg, data_idx_next;
    logic [15:0] win_start_reg, win_end_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] offset_reg;
    logic [7:0]  byte_reg;

    logic        in_fire;
    logic [3:0]  nib;
    logic [7:0]  pair_val;
    logic [15:0] byte_addr;
    logic [7:0]  data_idx_inc;
    logic        emit;

    assign in_ready     = !out_valid_reg || out_ready;
    assign in_fire      = in_valid && in_ready;
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign image_offset = offset_reg;
    assign data_byte    = byte_reg;

    assign nib          = hex_value(char_in);
    assign pair_val     = {high_reg[3:0], nib};
    assign byte_addr    = rec_addr_reg + {8'd0, data_idx_reg};
    assign data_idx_inc = data_idx_reg + 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        nib_idx_next  = nib_idx_reg;
        high_next     = high_reg;
        count_next    = count_reg;
        rec_addr_next = rec_addr_reg;
        rec_type_next = rec_type_reg;
        data_idx_next = data_idx_reg;
        emit          = 1'b0;
        if (in_fire)
        begin
            case (phase_reg)
                PH_ADDR:
                begin
                    if (nib_idx_reg != ADDR_LAST_NIBBLE)
                    begin
                        high_next    = {high_reg[7:0], nib};
                        nib_idx_next = nib_idx_reg + 2'd1;
                    end
                    else
                    begin
                        rec_addr_next = {high_reg, nib};
                        nib_idx_next  = 2'd0;
                        high_next     = 12'd0;
                        phase_next    = PH_TYPE;
                    end
                end
                PH_COUNT, PH_TYPE, PH_DATA, PH_CHECK:
                begin
                    if (nib_idx_reg == 2'd0)
                    begin
                        high_next    = {8'd0, nib};
                        nib_idx_next = 2'd1;
                    end
                    else
                    begin
                        nib_idx_next = 2'd0;
                        high_next    = 12'd0;
                        case (phase_reg)
                            PH_COUNT:
                            begin
                                count_next = pair_val;
                                phase_next = PH_ADDR;
                            end
                            PH_TYPE:
                            begin
                                rec_type_next = pair_val;
                                data_idx_next = 8'd0;
                                phase_next    = (count_reg != 8'd0) ? PH_DATA : PH_CHECK;
                            end
                            PH_DATA:
                            begin
                                emit = (rec_type_reg == 8'd0) && (byte_addr >= win_start_reg)
                                       && (byte_addr < win_end_reg);
                                data_idx_next = data_idx_inc;
                                if (data_idx_inc == count_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    if (char_in == CHAR_COLON)
                    begin
                        phase_next   = PH_COUNT;
                        nib_idx_next = 2'd0;
                        high_next    = 12'd0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            nib_idx_reg   <= 2'd0;
            high_reg      <= 12'd0;
            count_reg     <= 8'd0;
            rec_addr_reg  <= 16'd0;
            rec_type_reg  <= 8'd0;
            data_idx_reg  <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nib_idx_reg   <= nib_idx_next;
            high_reg      <= high_next;
            count_reg     <= count_next;
            rec_addr_reg  <= rec_addr_next;
            rec_type_reg  <= rec_type_next;
            data_idx_reg  <= data_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_start_reg <= 16'd0;
            win_end_reg   <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_WINDOW_START: win_start_reg <= cfg_data;
                CFG_WINDOW_END:   win_end_reg   <= cfg_data;
                default:          win_start_reg <= win_start_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            offset_reg <= byte_addr - win_start_reg;
            byte_reg   <= pair_val;
        end
    end

    `IHEX_ASSERT_NOW(a_emit_only_on_data_pair, clk, rst_n, emit,
        in_fire && phase_reg == PH_DATA && nib_idx_reg == 2'd1)
    `IHEX_ASSERT_NEXT(a_emit_fills_output, clk, rst_n, emit, out_valid_reg)
    `IHEX_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready,
        out_valid_reg && !out_ready)
    `IHEX_ASSERT_NOW(a_pair_index_narrow, clk, rst_n, phase_reg != PH_ADDR,
        nib_idx_reg == 2'd0 || nib_idx_reg == 2'd1)
    `IHEX_ASSERT_NOW(a_data_index_in_record, clk, rst_n, phase_reg == PH_DATA,
        count_reg != 8'd0 && data_idx_reg < count_reg)

endmodule

// File: sim/tb.sv
module tb;
    import ihex_pkg::*;

    typedef struct packed {
        logic [15:0] offset;
        logic [7:0]  value;
    } kept_byte_t;

    localparam int N_ROWS   = 15;
    localparam int N_PHASES = 8;
    localparam int PRESSURE_PHASE = 6;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  char_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] image_offset;
    logic [7:0]  data_byte;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    phase_t      ph;
    logic [1:0]  nib_cnt;
    logic [11:0] acc;
    logic [7:0]  rec_count;
    logic [7:0]  rec_type;
    logic [7:0]  rec_idx;
    logic [15:0] rec_addr;
    logic [15:0] win_lo;
    logic [15:0] win_hi;

    kept_byte_t  pending_bytes[$];
    kept_byte_t  want;

    int send_idle_pct;
    int recv_stall_pct;
    logic hold_off;
    logic pressure_go;
    int chars_sent;
    int bytes_seen;
    int mismatches;
    int windows_used;

    // directed rows: typed expectation overrides the predictor
    bit         row_typed;
    bit         row_pending;
    kept_byte_t row_value;

    string      row_text [N_ROWS];
    int         row_kind [N_ROWS];  // -1 predictor, 0 none, 1 one typed result
    kept_byte_t row_exp  [N_ROWS];

    localparam logic [15:0] PH_LO   [N_PHASES] = '{16'h0000, 16'h0000, 16'h1000, 16'hFFFF,
                                                 16'h8000, 16'hFFF0, 16'h0000, 16'h0000};
    localparam logic [15:0] PH_HI   [N_PHASES] = '{16'hFFFF, 16'h0000, 16'h1040, 16'hFFFF,
                                                 16'h0100, 16'hFFFF, 16'hFFFF, 16'h0000};
    localparam int          PH_MODE [N_PHASES] = '{0, 1, 2, 3, 0, 1, 0, 3};
    localparam int          PH_LEN  [N_PHASES] = '{300, 80, 120, 60, 60, 80, 120, 80};

    intel_hex_record_parser_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .image_offset (image_offset),
        .data_byte    (data_byte),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic bit parse_char(input logic [7:0] c, output kept_byte_t kept);
        logic [3:0]  nib;
        logic [7:0]  val;
        logic [15:0] a;
        kept = '0;
        nib = 4'd0;
        if (ph == PH_IDLE || ph > PH_CHECK)
        begin
            if (c == CHAR_COLON)
            begin
                ph = PH_COUNT;
                nib_cnt = 2'd0;
                acc = 12'd0;
            end
            else
            begin
                ph = PH_IDLE;
            end
            return 1'b0;
        end
        if (c >= CHAR_0 && c <= CHAR_9)
            nib = 4'(c - CHAR_0);
        else if (c >= CHAR_UA && c <= CHAR_UF)
            nib = 4'(c - CHAR_UA + HEX_TEN);
        else if (c >= CHAR_LA && c <= CHAR_LF)
            nib = 4'(c - CHAR_LA + HEX_TEN);
        if (ph == PH_ADDR)
        begin
            if (nib_cnt != ADDR_LAST_NIBBLE)
            begin
                acc = {acc[7:0], nib};
                nib_cnt = nib_cnt + 2'd1;
            end
            else
            begin
                rec_addr = {acc, nib};
                nib_cnt = 2'd0;
                acc = 12'd0;
                ph = PH_TYPE;
            end
            return 1'b0;
        end
        if (nib_cnt == 2'd0)
        begin
            acc = {8'd0, nib};
            nib_cnt = 2'd1;
            return 1'b0;
        end
        val = {acc[3:0], nib};
        nib_cnt = 2'd0;
        acc = 12'd0;
        case (ph)
            PH_COUNT:
            begin
                rec_count = val;
                ph = PH_ADDR;
            end
            PH_TYPE:
            begin
                rec_type = val;
                rec_idx = 8'd0;
                ph = (rec_count != 8'd0) ? PH_DATA : PH_CHECK;
            end
            PH_DATA:
            begin
                a = rec_addr + 16'(rec_idx);
                rec_idx = rec_idx + 8'd1;
                if (rec_idx == rec_count)
                    ph = PH_CHECK;
                if (rec_type == 8'd0 && a >= win_lo && a < win_hi)
                begin
                    kept.offset = a - win_lo;
                    kept.value = val;
                    return 1'b1;
                end
            end
            default:
            begin
                ph = PH_IDLE;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic send_char(input logic [7:0] c);
        kept_byte_t k;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        if (parse_char(c, k))
        begin
            if (!row_typed)
            begin
                pending_bytes.push_back(k);
            end
            else if (row_pending)
            begin
                pending_bytes.push_back(row_value);
                row_pending = 1'b0;
            end
        end
    endtask

    function automatic logic [7:0] digit_char(input logic [3:0] n);
        if ($urandom_range(0, 99) < 4)
            return 8'($urandom_range(0, 255));
        if (n < 4'd10)
            return CHAR_0 + 8'(n);
        return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(n) - HEX_TEN;
    endfunction

    task automatic send_record(input int force_count);
        logic [7:0]  fields[$];
        logic [7:0]  count;
        logic [7:0]  sum;
        logic [15:0] addr;
        int r;
        int stop;
        r = $urandom_range(0, 99);
        if (force_count >= 0)
            count = 8'(force_count);
        else if (r < 15)
            count = 8'd0;
        else if (r < 85)
            count = 8'($urandom_range(1, 16));
        else
            count = 8'($urandom_range(17, 64));
        r = $urandom_range(0, 99);
        if (r < 50)
            addr = win_lo + 16'($urandom_range(0, 80)) - 16'd8;
        else if (r < 70)
            addr = 16'hFFF0 + 16'($urandom_range(0, 15));
        else
            addr = 16'($urandom);
        fields = {count, addr[15:8], addr[7:0]};
        r = $urandom_range(0, 99);
        if (r < 70)
            fields.push_back(8'd0);
        else if (r < 85)
            fields.push_back(8'($urandom_range(1, 5)));
        else
            fields.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < count; i++)
            fields.push_back(8'($urandom_range(0, 255)));
        sum = 8'd0;
        foreach (fields[i])
            sum = sum + fields[i];
        fields.push_back(-sum);
        // a few records are cut short and leave the parser mid-record
        stop = fields.size() * 2;
        if ($urandom_range(0, 99) < 6)
            stop = $urandom_range(0, stop - 1);
        send_char(CHAR_COLON);
        for (int k = 0; k < stop; k++)
            send_char(digit_char(k[0] ? fields[k / 2][3:0] : fields[k / 2][7:4]));
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            send_char(8'h0D);
            send_char(8'h0A);
        end
        else if (r < 55)
        begin
            repeat ($urandom_range(1, 3))
                send_char(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic settle(input int extra);
        in_valid <= 1'b0;
        for (int w = 0; w < 5000 && pending_bytes.size() != 0; w++)
            @(posedge clk);
        repeat (extra)
            @(posedge clk);
    endtask

    task automatic set_window(input logic [15:0] lo, input logic [15:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_WINDOW_START;
        cfg_data <= lo;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_WINDOW_END;
        cfg_data <= hi;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        win_lo = lo;
        win_hi = hi;
        windows_used++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            bytes_seen++;
            if (pending_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: offset %h byte %h", image_offset, data_byte);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (image_offset !== want.offset || data_byte !== want.value)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected offset %h byte %h, got offset %h byte %h",
                                 want.offset, want.value, image_offset, data_byte);
                end
            end
        end
    end

    // long receiver hold-off so the output register fills and in_ready drops
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #6000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [15:0] lo;
        logic [15:0] hi;
        rst_n = 1'b0;
        in_valid = 1'b0;
        char_in = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = CFG_WINDOW_START;
        cfg_data = 16'd0;
        hold_off = 1'b0;
        pressure_go = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        chars_sent = 0;
        bytes_seen = 0;
        mismatches = 0;
        windows_used = 1;
        row_typed = 1'b0;
        row_pending = 1'b0;
        row_value = '0;
        ph = PH_IDLE;
        nib_cnt = 2'd0;
        acc = 12'd0;
        rec_count = 8'd0;
        rec_type = 8'd0;
        rec_idx = 8'd0;
        rec_addr = 16'd0;
        win_lo = 16'h0000;
        win_hi = 16'hFFFF;

        row_text = '{":01000000FF00", ":01FFFF000001", ":02FFFF00AB5500\r\n",
                     ":01123400ab00", ":01005000G7z0", ":01006000:500",
                     ":00000001FF\r\n", ":020000040000FA", ":00100000F0",
                     ":0120000000DF:01200100A5FF\n", ":03FFFE00C0C1C2AA\n", "xyz\n",
                     ":0:::000AA00", ":01abcd00Ef00", "\001\177\200\377\r\n"};
        row_kind = '{1, 0, 1, 1, 1, 1, 0, 0, 0, -1, -1, 0, 0, 1, 0};
        row_exp  = '{'{16'h0000, 8'hFF}, '0, '{16'h0000, 8'h55},
                     '{16'h1234, 8'hAB}, '{16'h0050, 8'h07}, '{16'h0060, 8'h05},
                     '0, '0, '0, '0, '0, '0, '0, '{16'hABCD, 8'hEF}, '0};

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed records under the reset window
        send_char(8'h00);
        for (int r = 0; r < N_ROWS; r++)
        begin
            row_typed = (row_kind[r] >= 0);
            row_pending = (row_kind[r] == 1);
            row_value = row_exp[r];
            for (int k = 0; k < row_text[r].len(); k++)
                send_char(row_text[r][k]);
        end
        row_typed = 1'b0;
        row_pending = 1'b0;

        for (int p = 0; p < N_PHASES; p++)
        begin
            settle(4);
            lo = PH_LO[p];
            hi = PH_HI[p];
            if (p == N_PHASES - 1)
            begin
                lo = 16'($urandom_range(0, 16'hF000));
                hi = lo + 16'($urandom_range(1, 16'h0FFF));
            end
            set_window(lo, hi);
            case (PH_MODE[p])
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                3: begin send_idle_pct = 32; recv_stall_pct = 32; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (p == PRESSURE_PHASE)
                pressure_go <= 1'b1;
            begin
                int start;
                start = chars_sent;
                if (p == 0)
                    send_record(255);
                while (chars_sent - start < PH_LEN[p])
                    send_record(-1);
            end
        end

        settle(10);
        mismatches += pending_bytes.size();
        $display("sent %0d characters under %0d window settings; %0d data bytes checked",
                 chars_sent, windows_used, bytes_seen);
        $display("%0d mismatches or missing bytes", mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
